@@ src/tba_pkg.sv @@
// Shared constants, types and helpers for the texture block allocator.
// No dependencies; every other file imports this package.
package tba_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int KEY_BITS   = 32;
    localparam int OWNER_W    = 8;
    localparam int IN_KEY_W   = 32;
    localparam int OUT_IDX_W  = 4;
    localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        WR_REUSE = 3'b001,
        WR_NEW   = 3'b010,
        WR_FREE  = 3'b100
    } t_wr_kind;

    // Search state handed from one cell to the next
    typedef struct packed {
        logic             hit_found;
        logic [IDX_W-1:0] hit_idx;
        logic             hit_reload;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
    } t_chain;

    // Table update broadcast to all cells
    typedef struct packed {
        logic                en;
        t_wr_kind            kind;
        logic [IDX_W-1:0]    idx;
        logic [OWNER_W-1:0]  owner;
        logic [KEY_BITS-1:0] key;
    } t_write;

    function automatic logic [KEY_BITS-1:0] to_key(input logic [IN_KEY_W-1:0] raw);
        logic [KEY_BITS+IN_KEY_W-1:0] ext;
        ext = {{KEY_BITS{1'b0}}, raw};
        return ext[KEY_BITS-1:0];
    endfunction

    function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W+OUT_IDX_W-1:0] ext;
        ext = {{OUT_IDX_W{1'b0}}, idx};
        return ext[OUT_IDX_W-1:0];
    endfunction

endpackage

@@ src/tba_if.sv @@
// Request and response channel interfaces for the texture block allocator.
// Depends on tba_pkg.
interface tba_req_if;
    import tba_pkg::*;
    logic                valid;
    logic                ready;
    logic                command;
    logic [OWNER_W-1:0]  owner_id;
    logic [IN_KEY_W-1:0] texture_key;

    modport source (output valid, command, owner_id, texture_key, input ready);
    modport sink   (input valid, command, owner_id, texture_key, output ready);
endinterface

interface tba_rsp_if;
    import tba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] block_index;
    logic                 reused;
    logic                 reload_needed;
    logic                 table_full;

    modport source (output valid, block_index, reused, reload_needed, table_full,
                    input ready);
    modport sink   (input valid, block_index, reused, reload_needed, table_full,
                    output ready);
endinterface

@@ src/tba_cell.sv @@
// One atlas block: owner, live flag and key, plus its link in the search chain.
// Depends on tba_pkg.
module tba_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [tba_pkg::IDX_W-1:0]    i_index,
    input  logic                         i_eval,
    input  logic [tba_pkg::OWNER_W-1:0]  i_owner,
    input  logic [tba_pkg::KEY_BITS-1:0] i_key,
    input  tba_pkg::t_cmd                i_cmd,
    input  tba_pkg::t_write              i_wr,
    input  tba_pkg::t_chain              i_chain,
    output tba_pkg::t_chain              o_chain
);
    import tba_pkg::*;

    logic [OWNER_W-1:0]  r_owner;
    logic                r_live;
    logic [KEY_BITS-1:0] r_key;
    logic                r_own_eq;
    logic                r_key_diff;
    logic                w_hit;
    logic                w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner <= '0;
            r_live  <= 1'b0;
            r_key   <= '0;
        end else if (i_wr.en && i_wr.idx == i_index) begin
            unique case (i_wr.kind)
                WR_REUSE: begin
                    r_live <= 1'b1;
                    r_key  <= i_wr.key;
                end
                WR_NEW: begin
                    r_owner <= i_wr.owner;
                    r_live  <= 1'b1;
                    r_key   <= i_wr.key;
                end
                WR_FREE: begin
                    r_live <= 1'b0;
                end
                default: begin
                    r_live <= r_live;
                end
            endcase
        end
    end

    // compare against the incoming request; held until the pick
    always_ff @(posedge i_clk) begin
        if (i_eval) begin
            r_own_eq   <= (r_owner == i_owner);
            r_key_diff <= (r_key != i_key);
        end
    end

    // release only matches a live block; allocate matches freed ones too
    assign w_hit  = (i_cmd == CMD_ALLOC) ? r_own_eq : (r_own_eq & r_live);
    assign w_free = ~r_live;

    always_comb begin
        o_chain.hit_found  = i_chain.hit_found | w_hit;
        o_chain.hit_idx    = i_chain.hit_found ? i_chain.hit_idx : i_index;
        o_chain.hit_reload = i_chain.hit_found ? i_chain.hit_reload : r_key_diff;
        o_chain.free_found = i_chain.free_found | w_free;
        o_chain.free_idx   = i_chain.free_found ? i_chain.free_idx : i_index;
    end

endmodule

@@ src/texture_block_allocator.sv @@
// Texture block allocator top level: request capture, chain of block cells,
// pick and response register. Depends on tba_pkg, tba_if and tba_cell.
//
// On acceptance every block cell compares its owner and key with the request in
// parallel; in the pick state the match and free flags ripple through the chain
// of cells, lowest block first, and the winning block is updated as the response
// is loaded, which waits while a held response is not yet taken. A new request is
// taken in the cycle after the previous pick, even while the response still waits;
// no request is taken during a pick. All blocks read as owner 0, free, key 0 after
// reset, with no clearing pass.
module texture_block_allocator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tba_req_if.sink          i_req,
    tba_rsp_if.source        o_rsp
);
    import tba_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_PICK = 2'b10
    } t_state;

    t_state              r_state, n_state;
    t_cmd                r_cmd;
    logic [OWNER_W-1:0]  r_owner;
    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] w_in_key;
    logic                w_accept;
    logic                w_load;
    logic                r_out_valid;
    logic [OUT_IDX_W-1:0] r_out_idx, n_out_idx;
    logic                r_out_reused, n_out_reused;
    logic                r_out_reload, n_out_reload;
    logic                r_out_full, n_out_full;
    t_write              w_wr;
    t_chain              w_chain [NUM_BLOCKS+1];

    assign w_in_key  = to_key(i_req.texture_key);
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept  = i_req.valid & i_req.ready;
    assign w_load    = (r_state == ST_PICK) & (~r_out_valid | o_rsp.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_PICK;
            ST_PICK: if (w_load)   n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load)
                r_out_valid <= 1'b1;
            else if (o_rsp.ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= t_cmd'(i_req.command);
            r_owner <= i_req.owner_id;
            r_key   <= w_in_key;
        end
        if (w_load) begin
            r_out_idx    <= n_out_idx;
            r_out_reused <= n_out_reused;
            r_out_reload <= n_out_reload;
            r_out_full   <= n_out_full;
        end
    end

    assign w_chain[0] = '0;

    for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
        tba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_eval  (w_accept),
            .i_owner (i_req.owner_id),
            .i_key   (w_in_key),
            .i_cmd   (r_cmd),
            .i_wr    (w_wr),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1])
        );
    end

    // pick from the end of the chain
    always_comb begin
        n_out_idx    = '0;
        n_out_reused = 1'b0;
        n_out_reload = 1'b0;
        n_out_full   = 1'b0;
        w_wr.en      = 1'b0;
        w_wr.kind    = WR_REUSE;
        w_wr.idx     = w_chain[NUM_BLOCKS].hit_idx;
        w_wr.owner   = r_owner;
        w_wr.key     = r_key;
        unique case (r_cmd)
            CMD_ALLOC: begin
                priority if (w_chain[NUM_BLOCKS].hit_found) begin
                    n_out_idx    = to_out_idx(w_chain[NUM_BLOCKS].hit_idx);
                    n_out_reused = 1'b1;
                    n_out_reload = w_chain[NUM_BLOCKS].hit_reload;
                    w_wr.en      = w_load;
                end else if (w_chain[NUM_BLOCKS].free_found) begin
                    n_out_idx    = to_out_idx(w_chain[NUM_BLOCKS].free_idx);
                    n_out_reload = 1'b1;
                    w_wr.en      = w_load;
                    w_wr.kind    = WR_NEW;
                    w_wr.idx     = w_chain[NUM_BLOCKS].free_idx;
                end else begin
                    n_out_full   = 1'b1;
                end
            end
            CMD_RELEASE: begin
                if (w_chain[NUM_BLOCKS].hit_found) begin
                    n_out_idx    = to_out_idx(w_chain[NUM_BLOCKS].hit_idx);
                    n_out_reused = 1'b1;
                    w_wr.en      = w_load;
                    w_wr.kind    = WR_FREE;
                end
            end
            default: begin
                w_wr.en = 1'b0;
            end
        endcase
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.block_index   = r_out_idx;
    assign o_rsp.reused        = r_out_reused;
    assign o_rsp.reload_needed = r_out_reload;
    assign o_rsp.table_full    = r_out_full;

endmodule

@@ tb/tba_checker.sv @@
`timescale 1ns / 100ps
// Response checker for the texture block allocator: watches both channels, keeps its
// own copy of the block table and checks every response in order. Uses tba_pkg, tba_if.
module tba_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    tba_req_if   i_req,
    tba_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    import tba_pkg::*;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] block_index;
        logic                 reused;
        logic                 reload_needed;
        logic                 table_full;
    } t_grant;

    logic [OWNER_W-1:0]  tab_owner [NUM_BLOCKS];
    logic                tab_live  [NUM_BLOCKS];
    logic [KEY_BITS-1:0] tab_key   [NUM_BLOCKS];

    t_grant grant_q [$];
    int     fails = 0;

    // Applies one request to the table copy and returns the grant it should produce
    function automatic t_grant grant_for(t_cmd cmd, logic [OWNER_W-1:0] who,
                                         logic [KEY_BITS-1:0] key);
        t_grant g;
        g = '0;
        if (cmd == CMD_RELEASE) begin
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                if (tab_live[i] && tab_owner[i] == who) begin
                    tab_live[i]   = 1'b0;
                    g.block_index = OUT_IDX_W'(i);
                    g.reused      = 1'b1;
                    return g;
                end
            end
            return g;
        end
        // owner match wins over a free block, live or freed alike
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            if (tab_owner[i] == who) begin
                g.block_index   = OUT_IDX_W'(i);
                g.reused        = 1'b1;
                g.reload_needed = (tab_key[i] != key);
                tab_live[i]     = 1'b1;
                tab_key[i]      = key;
                return g;
            end
        end
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            if (!tab_live[i]) begin
                g.block_index   = OUT_IDX_W'(i);
                g.reload_needed = 1'b1;
                tab_owner[i]    = who;
                tab_live[i]     = 1'b1;
                tab_key[i]      = key;
                return g;
            end
        end
        g.table_full = 1'b1;
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_grant want;
        t_grant got;
        t_grant fresh;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                tab_owner[i] = '0;
                tab_live[i]  = 1'b0;
                tab_key[i]   = '0;
            end
            grant_q.delete();
        end else begin
            // response first: it always belongs to an older request
            if (i_rsp.valid && i_rsp.ready) begin
                got = {i_rsp.block_index, i_rsp.reused, i_rsp.reload_needed,
                       i_rsp.table_full};
                if (grant_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: response with none pending: %s %0d %s %b %s %b %s %b",
                                 $time, "idx", got.block_index, "reused", got.reused,
                                 "reload", got.reload_needed, "full", got.table_full);
                end else begin
                    want = grant_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: mismatch: expected idx=%0d reused=%b %s=%b full=%b",
                                     $time, want.block_index, want.reused, "reload",
                                     want.reload_needed, want.table_full);
                            $display("%0t:           got      idx=%0d reused=%b %s=%b full=%b",
                                     $time, got.block_index, got.reused, "reload",
                                     got.reload_needed, got.table_full);
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                fresh = grant_for(t_cmd'(i_req.command), i_req.owner_id,
                                  i_req.texture_key);
                grant_q.insert(grant_q.size(), fresh);
            end
        end
        o_fail_count <= fails;
        o_pending    <= grant_q.size();
    end

endmodule

@@ tb/tb_texture_block_allocator.sv @@
`timescale 1ns / 100ps
// Top of the texture block allocator testbench: clock, reset, request stimulus and
// response back-pressure, with the verdict. Uses tba_pkg, tba_if and tba_checker.
module tb_texture_block_allocator;
    import tba_pkg::*;

    localparam int PHASES          = 5;
    localparam int PHASE_ITEMS     = 245;
    localparam int RSP_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int TIMEOUT_NS      = 2_000_000;

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;
    bit   hold_rsp;
    int   fail_count;
    int   pending;
    int   n_alloc;
    int   n_release;
    bit [IN_KEY_W-1:0] last_key [256];

    tba_req_if req_if ();
    tba_rsp_if rsp_if ();

    texture_block_allocator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    tba_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Simulation timed out with %0d responses outstanding", pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Response back-pressure: random stall bursts, plus one long hold on request
    initial begin
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_rsp) begin
                rsp_if.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(negedge i_clk);
                hold_rsp = 1'b0;
                rsp_if.ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Offers one request, optionally after a gap, and returns once it is taken
    task automatic put_request(t_cmd cmd, logic [OWNER_W-1:0] who, logic [IN_KEY_W-1:0] key);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.command     <= cmd;
        req_if.owner_id    <= who;
        req_if.texture_key <= key;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (cmd == CMD_ALLOC) begin
            n_alloc++;
            last_key[who] = key;
        end else begin
            n_release++;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [OWNER_W-1:0]  pool [24];
        int                  pool_size;
        t_cmd                cmd;
        logic [OWNER_W-1:0]  who;
        logic [IN_KEY_W-1:0] key;

        req_if.valid       = 1'b0;
        req_if.command     = CMD_ALLOC;
        req_if.owner_id    = '0;
        req_if.texture_key = '0;
        idle_on   = 1'b1;
        hold_rsp  = 1'b0;
        n_alloc   = 0;
        n_release = 0;
        wait (i_rst_n === 1'b1);

        // owner zero owns every block after reset
        put_request(CMD_ALLOC, 8'h00, 32'h0000_0000);
        put_request(CMD_ALLOC, 8'h00, 32'h0000_0001);
        put_request(CMD_RELEASE, 8'h00, 32'h0000_0000);
        put_request(CMD_RELEASE, 8'h00, 32'h0000_0000);   // nothing live left
        put_request(CMD_ALLOC, 8'hFF, 32'hFFFF_FFFF);
        put_request(CMD_ALLOC, 8'hFF, 32'hFFFF_FFFF);     // reuse, same key
        put_request(CMD_ALLOC, 8'h80, 32'h8000_0000);
        put_request(CMD_ALLOC, 8'h7F, 32'h7FFF_FFFF);
        for (int o = 1; o <= 13; o++)
            put_request(CMD_ALLOC, OWNER_W'(o), IN_KEY_W'(o));
        put_request(CMD_ALLOC, 8'h40, 32'h0000_0040);     // table full
        put_request(CMD_RELEASE, 8'hFF, 32'h5555_5555);
        put_request(CMD_ALLOC, 8'h41, 32'h0000_0000);     // takes the freed block
        put_request(CMD_RELEASE, 8'h99, 32'hAAAA_AAAA);   // owner never allocated

        for (int ph = 0; ph < PHASES; ph++) begin
            pool_size = $urandom_range(12, 24);
            foreach (pool[j]) pool[j] = OWNER_W'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1) pool[0] = '0;
            if (ph == 1) hold_rsp = 1'b1;     // sender keeps offering meanwhile
            if (ph == 2) wait_drained();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    idle_on = (ph < PHASES - 1) && ($urandom_range(0, 9) < 7);
                who = pool[$urandom_range(0, pool_size - 1)];
                cmd = ($urandom_range(0, 99) < 58) ? CMD_ALLOC : CMD_RELEASE;
                case ($urandom_range(0, 4))
                    0:       key = last_key[who];
                    1:       key = '0;
                    2:       key = '1;
                    3:       key = $urandom_range(1, 3);
                    default: key = $urandom;
                endcase
                put_request(cmd, who, key);
            end
        end

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d allocate and %0d release requests across %0d owner pools,",
                 n_alloc, n_release, PHASES);
        $display("including table-full cases, a long response hold and a full drain pause.");
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ texture_block_allocator.f @@
src/tba_pkg.sv
src/tba_if.sv
src/tba_cell.sv
src/texture_block_allocator.sv
tb/tba_checker.sv
tb/tb_texture_block_allocator.sv
